FILE: sv/mwe_pkg.sv
// ----------------------------------------------------------------------------
// mwe_pkg
// Shared types and codes for the multichannel weight envelope unit.
// ----------------------------------------------------------------------------
package mwe_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_RAMP_F = 3'd1;
    localparam logic [2:0] OP_RAMP_S = 3'd2;
    localparam logic [2:0] OP_ACCEL  = 3'd3;
    localparam logic [2:0] OP_BOUNCE = 3'd4;
    localparam logic [2:0] OP_BEAT   = 3'd5;
    localparam logic [2:0] OP_STOP   = 3'd6;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_LINEAR = 3'd1;
    localparam logic [2:0] MODE_ACCEL  = 3'd2;
    localparam logic [2:0] MODE_BOUNCE = 3'd3;
    localparam logic [2:0] MODE_BEAT   = 3'd4;

    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;

    // per-channel control record, kept in one memory word
    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] half_count;
        logic [15:0] half_limit;
        logic [1:0]  beat_phase;
        logic [15:0] beat_tick;
        logic [15:0] rise_len;
        logic [15:0] fall_len;
        logic [15:0] period_len;
    } ctl_t;

    localparam int CTL_BITS = $bits(ctl_t);

endpackage

FILE: sv/mwe_ram.sv
// ----------------------------------------------------------------------------
// mwe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/mwe_div.sv
// ----------------------------------------------------------------------------
// mwe_div
// Restoring divider: signed numerator by 16-bit unsigned denominator,
// truncating toward zero, saturated to the weight range, zero on zero divide.
// ----------------------------------------------------------------------------
module mwe_div #(
    parameter int NB = 34,
    parameter int WB = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NB-1:0] num,
    input  logic [15:0]          den,
    output logic                 done,
    output logic signed [WB-1:0] quot
);

    localparam int CW = $clog2(NB + 1);
    localparam logic signed [WB:0] HI = (WB+1)'((64'sd1 <<< (WB - 1)) - 1);
    localparam logic signed [WB:0] LO = -HI - 1;

    logic [NB-1:0] q_reg, q_next;
    logic [16:0]   r_reg, r_next;
    logic [15:0]   d_reg;
    logic          neg_reg, busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [16:0]   trial;
    logic signed [NB:0]  sq;
    logic signed [WB:0]  qs;

    assign trial = {r_reg[15:0], q_reg[NB-1]} - {1'b0, d_reg};

    always_comb begin
        q_next = {q_reg[NB-2:0], 1'b0};
        r_next = {r_reg[15:0], q_reg[NB-1]};
        if (!trial[16]) begin
            r_next    = trial;
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= (den != 16'd0);
                done_reg <= (den == 16'd0);
                cnt_reg  <= CW'(NB);
                neg_reg  <= num[NB-1];
                q_reg    <= num[NB-1] ? NB'(-num) : NB'(num);
                r_reg    <= '0;
                d_reg    <= den;
            end else if (busy_reg) begin
                q_reg   <= q_next;
                r_reg   <= r_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        sq = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        if (d_reg == 16'd0)        qs = '0;
        else if (sq > (NB+1)'(HI)) qs = HI;
        else if (sq < (NB+1)'(LO)) qs = LO;
        else                       qs = (WB+1)'(sq);
    end

    assign done = done_reg;
    assign quot = qs[WB-1:0];

endmodule

FILE: sv/multichannel_weight_envelope_unit.sv
// ----------------------------------------------------------------------------
// multichannel_weight_envelope_unit
// Per-channel envelope generator, Q16.16 weights, state held in RAM.
// ----------------------------------------------------------------------------
// A tick steps each active channel through the read, load, tick, write and
// output states, with a divide wait for a channel entering a beat phase that
// needs a new velocity; result stalls hold it in the output state.
// A start command holds s_ready low until it is written back, also while it divides.
// One item at a time; the next is taken once the last result beat is taken.
// Reset (synchronous, aresetn low) clears control state, then a sweep over the
// CHANNELS entries writes reset values into the memories before input is taken.
module multichannel_weight_envelope_unit
    import mwe_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int WEIGHT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [2:0]  s_channel,
    input  logic signed [31:0] s_target_weight,
    input  logic signed [31:0] s_rate,
    input  logic signed [31:0] s_accel,
    input  logic [15:0] s_frames,
    input  logic [15:0] s_attack_frames,
    input  logic [15:0] s_rest_frames,
    input  logic [15:0] s_half_loops,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_channel,
    output logic signed [31:0] m_weight,
    output logic        m_busy_res,
    output logic        m_last
);

    localparam int WB = WEIGHT_BITS;
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam int DW = 4 * WB;
    localparam int NB = WB + 2;
    localparam logic signed [WB+1:0] HI = (WB+2)'((64'sd1 <<< (WB - 1)) - 1);
    localparam logic signed [WB+1:0] LO = -HI - 1;

    localparam logic [3:0] ST_INIT = 4'd0, ST_IDLE = 4'd1, ST_RD = 4'd2,
        ST_CMD = 4'd3, ST_TICK = 4'd4, ST_DIVW = 4'd5, ST_WR = 4'd6,
        ST_OUT = 4'd7, ST_NEXT = 4'd8, ST_LD = 4'd9;

    function automatic logic signed [WB-1:0] sat(input logic signed [WB+1:0] v);
        if (v > HI)      sat = HI[WB-1:0];
        else if (v < LO) sat = LO[WB-1:0];
        else             sat = v[WB-1:0];
    endfunction

    function automatic logic signed [WB-1:0] sx(input logic [31:0] v);
        sx = sat((WB+2)'($signed(v)));
    endfunction

    function automatic logic signed [WB+1:0] ext(input logic signed [WB-1:0] v);
        ext = (WB+2)'(v);
    endfunction

    logic [3:0]    st_reg;
    logic [AW-1:0] ch_reg;
    logic [CW-1:0] n_reg;
    logic [3:0]    active_reg;
    logic signed [WB-1:0] top_reg, bot_reg;
    logic [2:0]  op_reg;
    logic signed [WB-1:0] tw_reg, rt_reg, ac_reg;
    logic [15:0] fr_reg, at_reg, rs_reg, hl_reg;

    // working copy of one channel
    logic signed [WB-1:0] lv_reg, vl_reg, acc_reg, gl_reg;
    ctl_t ctl_reg;

    logic          we;
    logic [AW-1:0] raddr;
    logic [DW-1:0] d_rd, d_wr;
    logic [CTL_BITS-1:0] c_rd;
    ctl_t c_wr;

    logic                 div_start, div_done;
    logic signed [NB-1:0] div_num;
    logic [15:0]          div_den;
    logic signed [WB-1:0] div_q;

    logic [CW-1:0] n_eff;
    logic          out_v_reg;

    mwe_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_data (
        .aclk(aclk), .we(we), .waddr(ch_reg), .wdata(d_wr),
        .raddr(raddr), .rdata(d_rd)
    );

    mwe_ram #(.WIDTH(CTL_BITS), .DEPTH(1 << AW)) u_ctl (
        .aclk(aclk), .we(we), .waddr(ch_reg), .wdata(c_wr),
        .raddr(raddr), .rdata(c_rd)
    );

    mwe_div #(.NB(NB), .WB(WB)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quot(div_q)
    );

    assign raddr = ch_reg;
    assign we    = (st_reg == ST_INIT) || (st_reg == ST_WR);
    always_comb begin
        if (st_reg == ST_INIT) begin
            d_wr = '0;
            c_wr = '{mode: MODE_IDLE, half_limit: 16'hFFFF, default: '0};
        end else begin
            d_wr = {lv_reg, vl_reg, acc_reg, gl_reg};
            c_wr = ctl_reg;
        end
    end

    always_comb begin
        n_eff = (CW)'(active_reg > 4'd8 ? 4'd8 : active_reg);
        if (n_eff > CW'(CHANNELS)) n_eff = CW'(CHANNELS);
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (st_reg == ST_IDLE);
    assign m_valid   = out_v_reg;

    // tick working values, computed from the copy loaded at ST_LD
    logic signed [WB-1:0] t_lv, t_vl;
    ctl_t t_ctl;
    logic t_div;
    logic signed [NB-1:0] t_num;
    logic [15:0] t_den;
    logic [15:0] t_hc;

    always_comb begin
        t_lv  = lv_reg;
        t_vl  = vl_reg;
        t_ctl = ctl_reg;
        t_div = 1'b0;
        t_num = '0;
        t_den = '0;
        t_hc  = ctl_reg.half_count + 16'd1;
        case (ctl_reg.mode)
            MODE_LINEAR, MODE_ACCEL: begin
                t_lv = sat(ext(lv_reg) + ext(vl_reg));
                if ((vl_reg > 0 && gl_reg < t_lv) || (vl_reg < 0 && gl_reg > t_lv)) begin
                    t_lv = gl_reg;
                    t_ctl.mode = MODE_IDLE;
                end
                if (t_ctl.mode == MODE_ACCEL) t_vl = sat(ext(vl_reg) + ext(acc_reg));
            end
            MODE_BOUNCE: begin
                t_lv = sat(ext(lv_reg) + ext(vl_reg));
                if (top_reg < t_lv || bot_reg > t_lv) begin
                    t_lv = (top_reg < t_lv) ? top_reg : bot_reg;
                    t_vl = sat(-ext(vl_reg));
                    t_ctl.half_count = t_hc;
                    if (t_hc == ctl_reg.half_limit) t_ctl.mode = MODE_IDLE;
                end
            end
            MODE_BEAT: begin
                t_ctl.beat_tick = ctl_reg.beat_tick + 16'd1;
                case (ctl_reg.beat_phase)
                    2'd0: begin
                        t_lv = sat(ext(lv_reg) + ext(vl_reg));
                        if (t_ctl.beat_tick >= ctl_reg.rise_len) begin
                            t_lv = top_reg;
                            t_div = 1'b1;
                            t_num = NB'(ext(bot_reg) - ext(top_reg));
                            t_den = ctl_reg.fall_len;
                            t_ctl.half_count = t_hc;
                            if (t_hc == ctl_reg.half_limit) t_ctl.mode = MODE_IDLE;
                            t_ctl.beat_phase = 2'd1;
                        end
                    end
                    2'd1: begin
                        t_lv = sat(ext(lv_reg) + ext(vl_reg));
                        if ({1'b0, t_ctl.beat_tick} >=
                            {1'b0, ctl_reg.rise_len} + {1'b0, ctl_reg.fall_len}) begin
                            t_lv = bot_reg;
                            t_vl = '0;
                            t_ctl.beat_phase = 2'd2;
                        end
                    end
                    default: begin
                        if (t_ctl.beat_tick >= ctl_reg.period_len) begin
                            t_ctl.half_count = t_hc;
                            if (t_hc == ctl_reg.half_limit) t_ctl.mode = MODE_IDLE;
                            t_div = 1'b1;
                            t_num = NB'(ext(top_reg) - ext(lv_reg));
                            t_den = ctl_reg.rise_len;
                            t_ctl.beat_tick = '0;
                            t_ctl.beat_phase = 2'd0;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    // command working values
    logic signed [WB-1:0] k_lv, k_vl, k_acc, k_gl;
    ctl_t k_ctl;
    logic k_div;
    logic signed [NB-1:0] k_num;
    logic [15:0] k_den, k_fall;

    always_comb begin
        k_lv  = lv_reg;
        k_vl  = vl_reg;
        k_acc = acc_reg;
        k_gl  = gl_reg;
        k_ctl = ctl_reg;
        k_div = 1'b0;
        k_num = '0;
        k_den = '0;
        k_fall = fr_reg - at_reg - rs_reg;
        case (op_reg)
            OP_RAMP_F: begin
                k_ctl.mode = MODE_LINEAR;
                k_gl  = tw_reg;
                k_div = 1'b1;
                k_num = NB'(ext(tw_reg) - ext(lv_reg));
                k_den = fr_reg;
            end
            OP_RAMP_S: begin
                k_ctl.mode = MODE_LINEAR;
                k_gl = tw_reg;
                if (tw_reg > lv_reg)      k_vl = rt_reg;
                else if (tw_reg < lv_reg) k_vl = sat(-ext(rt_reg));
                else                      k_vl = '0;
            end
            OP_ACCEL: begin
                k_ctl.mode = MODE_ACCEL;
                k_gl  = tw_reg;
                k_vl  = rt_reg;
                k_acc = ac_reg;
            end
            OP_BOUNCE: begin
                k_ctl.mode = MODE_BOUNCE;
                k_ctl.half_count = '0;
                k_ctl.half_limit = hl_reg;
                k_div = 1'b1;
                k_num = NB'(131072);
                k_den = fr_reg;
            end
            OP_BEAT: begin
                k_ctl.mode = MODE_BEAT;
                k_ctl.half_count = '0;
                k_ctl.half_limit = hl_reg;
                k_ctl.rise_len = at_reg;
                k_ctl.period_len = fr_reg;
                k_ctl.fall_len = k_fall;
                k_ctl.beat_tick = '0;
                k_div = 1'b1;
                if (at_reg != 16'd0) begin
                    k_num = NB'(ext(top_reg) - ext(lv_reg));
                    k_den = at_reg;
                    k_ctl.beat_phase = 2'd0;
                end else begin
                    k_lv = top_reg;
                    k_num = NB'(ext(bot_reg) - ext(top_reg));
                    k_den = k_fall;
                    k_ctl.half_count = 16'd1;
                    k_ctl.beat_phase = 2'd1;
                end
            end
            default: k_ctl.mode = MODE_IDLE;
        endcase
    end

    assign div_start = (st_reg == ST_CMD && k_div) || (st_reg == ST_TICK && t_div);
    assign div_num   = (st_reg == ST_CMD) ? k_num : t_num;
    assign div_den   = (st_reg == ST_CMD) ? k_den : t_den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_INIT;
            ch_reg     <= '0;
            out_v_reg  <= 1'b0;
            active_reg <= 4'd8;
            top_reg    <= sx(32'd65536);
            bot_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ACTIVE: active_reg <= cfg_data[3:0];
                    REG_TOP:    top_reg    <= sx(cfg_data);
                    REG_BOTTOM: bot_reg    <= sx(cfg_data);
                    default: ;
                endcase
            end
            case (st_reg)
                ST_INIT: begin
                    if (ch_reg == AW'(CHANNELS - 1) || (1 << AW) == 1) begin
                        ch_reg <= '0;
                        st_reg <= ST_IDLE;
                    end else begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg <= s_op;
                        tw_reg <= sx(s_target_weight);
                        rt_reg <= sx(s_rate);
                        ac_reg <= sx(s_accel);
                        fr_reg <= s_frames;
                        at_reg <= s_attack_frames;
                        rs_reg <= s_rest_frames;
                        hl_reg <= s_half_loops;
                        n_reg  <= n_eff;
                        if (s_op == OP_TICK) begin
                            ch_reg <= '0;
                            if (n_eff != '0) st_reg <= ST_RD;
                        end else if (s_op != 3'd7 && {1'b0, s_channel} < 4'(CHANNELS)) begin
                            ch_reg <= AW'(s_channel);
                            st_reg <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    st_reg <= ST_LD;
                end
                ST_LD: begin
                    // read data for ch_reg is on the ram outputs now
                    lv_reg  <= d_rd[DW-1 -: WB];
                    vl_reg  <= d_rd[3*WB-1 -: WB];
                    acc_reg <= d_rd[2*WB-1 -: WB];
                    gl_reg  <= d_rd[WB-1:0];
                    ctl_reg <= ctl_t'(c_rd);
                    st_reg  <= (op_reg == OP_TICK) ? ST_TICK : ST_CMD;
                end
                ST_CMD, ST_TICK: begin
                    if (st_reg == ST_CMD) begin
                        lv_reg <= k_lv; vl_reg <= k_vl; acc_reg <= k_acc;
                        gl_reg <= k_gl; ctl_reg <= k_ctl;
                        st_reg <= k_div ? ST_DIVW : ST_WR;
                    end else begin
                        lv_reg <= t_lv; vl_reg <= t_vl; ctl_reg <= t_ctl;
                        st_reg <= t_div ? ST_DIVW : ST_WR;
                    end
                end
                ST_DIVW: begin
                    if (div_done) begin
                        vl_reg <= div_q;
                        st_reg <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (op_reg == OP_TICK) begin
                        out_v_reg     <= 1'b1;
                        m_out_channel <= 3'(ch_reg);
                        m_weight      <= 32'(lv_reg);
                        m_busy_res    <= (ctl_reg.mode != MODE_IDLE);
                        m_last        <= (CW'(ch_reg) + CW'(1) == n_reg);
                        st_reg        <= ST_OUT;
                    end else begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        out_v_reg <= 1'b0;
                        if (CW'(ch_reg) + CW'(1) == n_reg) begin
                            st_reg <= ST_IDLE;
                        end else begin
                            ch_reg <= ch_reg + 1'b1;
                            st_reg <= ST_RD;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: test/multichannel_weight_envelope_checker.sv
// ----------------------------------------------------------------------------
// multichannel_weight_envelope_checker
// Watches the config, command and weight channels of the envelope unit,
// keeps its own copy of every channel's envelope state, predicts the weight
// beats of each tick and compares them in order with what the unit sends.
// ----------------------------------------------------------------------------
module multichannel_weight_envelope_checker
    import mwe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [2:0]  s_channel,
    input  logic [31:0] s_target_weight,
    input  logic [31:0] s_rate,
    input  logic [31:0] s_accel,
    input  logic [15:0] s_frames,
    input  logic [15:0] s_attack_frames,
    input  logic [15:0] s_rest_frames,
    input  logic [15:0] s_half_loops,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_out_channel,
    input  logic [31:0] m_weight,
    input  logic        m_busy_res,
    input  logic        m_last,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = 8;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    typedef struct {
        logic [2:0]  chan;
        logic [31:0] weight;
        logic        busy;
        logic        last;
    } weight_beat_t;

    weight_beat_t expected_weights[$];

    longint      lvl[NCH], vel[NCH], acc[NCH], goal_w[NCH];
    logic [2:0]  md[NCH];
    logic [15:0] hcount[NCH], hlimit[NCH], btick[NCH], rise[NCH], fall[NCH], per[NCH];
    logic [1:0]  bphase[NCH];
    logic [3:0]  n_active;
    longint      top_w, bot_w;

    function automatic longint clip(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint sext(logic [31:0] x);
        return longint'(signed'(x));
    endfunction

    function automatic longint qdiv(longint num, logic [15:0] den);
        if (den == 16'd0) return 0;
        return clip(num / longint'(den));
    endfunction

    function automatic void clear_state();
        for (int c = 0; c < NCH; c++) begin
            lvl[c] = 0; vel[c] = 0; acc[c] = 0; goal_w[c] = 0;
            md[c] = MODE_IDLE; hcount[c] = '0; hlimit[c] = '1;
            bphase[c] = '0; btick[c] = '0; rise[c] = '0; fall[c] = '0; per[c] = '0;
        end
        n_active = 4'd8;
        top_w = 65536;
        bot_w = 0;
    endfunction

    function automatic void count_half(int c);
        hcount[c] = hcount[c] + 16'd1;
        if (hcount[c] == hlimit[c]) md[c] = MODE_IDLE;
    endfunction

    function automatic void step_channel(int c);
        if (md[c] == MODE_LINEAR || md[c] == MODE_ACCEL) begin
            lvl[c] = clip(lvl[c] + vel[c]);
            if ((vel[c] > 0 && goal_w[c] < lvl[c]) || (vel[c] < 0 && goal_w[c] > lvl[c])) begin
                lvl[c] = goal_w[c];
                md[c] = MODE_IDLE;
            end
        end
        if (md[c] == MODE_BOUNCE) begin
            lvl[c] = clip(lvl[c] + vel[c]);
            if (top_w < lvl[c]) begin
                lvl[c] = top_w;
                vel[c] = clip(-vel[c]);
                count_half(c);
            end else if (bot_w > lvl[c]) begin
                lvl[c] = bot_w;
                vel[c] = clip(-vel[c]);
                count_half(c);
            end
        end else if (md[c] == MODE_BEAT) begin
            btick[c] = btick[c] + 16'd1;
            if (bphase[c] == 2'd0) begin
                lvl[c] = clip(lvl[c] + vel[c]);
                if (btick[c] >= rise[c]) begin
                    lvl[c] = top_w;
                    vel[c] = qdiv(bot_w - top_w, fall[c]);
                    count_half(c);
                    bphase[c] = 2'd1;
                end
            end else if (bphase[c] == 2'd1) begin
                lvl[c] = clip(lvl[c] + vel[c]);
                if (int'(btick[c]) >= int'(rise[c]) + int'(fall[c])) begin
                    lvl[c] = bot_w;
                    vel[c] = 0;
                    bphase[c] = 2'd2;
                end
            end else if (btick[c] >= per[c]) begin
                count_half(c);
                vel[c] = qdiv(top_w - lvl[c], rise[c]);
                btick[c] = '0;
                bphase[c] = 2'd0;
            end
        end
    endfunction

    function automatic void predict_command();
        int c;
        int n;
        longint tw;
        weight_beat_t b;
        c = int'(s_channel);
        tw = sext(s_target_weight);
        if (s_op == OP_TICK) begin
            n = (n_active > 4'd8) ? 8 : int'(n_active);
            for (int i = 0; i < n; i++) begin
                step_channel(i);
                if (md[i] == MODE_ACCEL) vel[i] = clip(vel[i] + acc[i]);
                b.chan = 3'(i);
                b.weight = lvl[i][31:0];
                b.busy = (md[i] != MODE_IDLE);
                b.last = (i == n - 1);
                expected_weights.push_back(b);
            end
            return;
        end
        case (s_op)
            OP_RAMP_F: begin
                md[c] = MODE_LINEAR;
                goal_w[c] = tw;
                vel[c] = qdiv(tw - lvl[c], s_frames);
            end
            OP_RAMP_S: begin
                md[c] = MODE_LINEAR;
                goal_w[c] = tw;
                if (tw > lvl[c]) vel[c] = sext(s_rate);
                else if (tw < lvl[c]) vel[c] = clip(-sext(s_rate));
                else vel[c] = 0;
            end
            OP_ACCEL: begin
                md[c] = MODE_ACCEL;
                goal_w[c] = tw;
                vel[c] = sext(s_rate);
                acc[c] = sext(s_accel);
            end
            OP_BOUNCE: begin
                md[c] = MODE_BOUNCE;
                hcount[c] = '0;
                hlimit[c] = s_half_loops;
                vel[c] = qdiv(131072, s_frames);
            end
            OP_BEAT: begin
                md[c] = MODE_BEAT;
                hcount[c] = '0;
                hlimit[c] = s_half_loops;
                rise[c] = s_attack_frames;
                per[c] = s_frames;
                fall[c] = s_frames - s_attack_frames - s_rest_frames;
                btick[c] = '0;
                if (s_attack_frames != 16'd0) begin
                    vel[c] = qdiv(top_w - lvl[c], s_attack_frames);
                    bphase[c] = 2'd0;
                end else begin
                    lvl[c] = top_w;
                    vel[c] = qdiv(bot_w - top_w, fall[c]);
                    hcount[c] = 16'd1;
                    bphase[c] = 2'd1;
                end
            end
            OP_STOP: md[c] = MODE_IDLE;
            default: ;
        endcase
    endfunction

    task automatic report(string what);
        $display("%0t mismatch: %s", $realtime, what);
        errors++;
    endtask

    initial begin
        errors = 0;
        pending = 0;
        clear_state();
    end

    always @(posedge aclk) begin
        weight_beat_t e;
        if (!aresetn) begin
            clear_state();
            expected_weights.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_weights.size() == 0) begin
                    report($sformatf("unexpected weight beat ch %0d w %h",
                                     m_out_channel, m_weight));
                end else begin
                    e = expected_weights.pop_front();
                    if (m_out_channel !== e.chan)
                        report($sformatf("channel got %0d want %0d", m_out_channel, e.chan));
                    if (m_weight !== e.weight)
                        report($sformatf("ch %0d weight got %h want %h",
                                         e.chan, m_weight, e.weight));
                    if (m_busy_res !== e.busy)
                        report($sformatf("ch %0d busy got %b want %b",
                                         e.chan, m_busy_res, e.busy));
                    if (m_last !== e.last)
                        report($sformatf("ch %0d last got %b want %b",
                                         e.chan, m_last, e.last));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ACTIVE: n_active = cfg_data[3:0];
                    REG_TOP:    top_w = sext(cfg_data);
                    REG_BOTTOM: bot_w = sext(cfg_data);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_command();
        end
        pending = expected_weights.size();
    end

endmodule

FILE: test/multichannel_weight_envelope_unit_tb.sv
// ----------------------------------------------------------------------------
// multichannel_weight_envelope_unit_tb
// Drives directed and random envelope commands and ticks across several
// register settings and idling patterns; the checker does the comparison.
// ----------------------------------------------------------------------------
module multichannel_weight_envelope_unit_tb;
    import mwe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [2:0]  s_channel = '0;
    logic signed [31:0] s_target_weight = '0;
    logic signed [31:0] s_rate = '0;
    logic signed [31:0] s_accel = '0;
    logic [15:0] s_frames = '0;
    logic [15:0] s_attack_frames = '0;
    logic [15:0] s_rest_frames = '0;
    logic [15:0] s_half_loops = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_out_channel;
    logic signed [31:0] m_weight;
    logic        m_busy_res;
    logic        m_last;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;

    multichannel_weight_envelope_unit DUT (.*);
    multichannel_weight_envelope_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_cmd(logic [2:0] op, logic [2:0] ch, logic [31:0] tw, logic [31:0] rt,
                            logic [31:0] ac, logic [15:0] fr, logic [15:0] at,
                            logic [15:0] rs, logic [15:0] hl);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_op = op; s_channel = ch; s_target_weight = tw; s_rate = rt; s_accel = ac;
        s_frames = fr; s_attack_frames = at; s_rest_frames = rs; s_half_loops = hl;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic tick();
        send_cmd(OP_TICK, 3'($urandom), $urandom, $urandom, $urandom,
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // mostly modest Q16.16 values, now and then a full-range word
    function automatic logic [31:0] rand_q();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
    endfunction

    function automatic logic [15:0] rand_len();
        if ($urandom_range(19) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 12));
    endfunction

    task automatic random_item();
        logic [2:0] op;
        if ($urandom_range(99) < 45) op = OP_TICK;
        else if ($urandom_range(29) == 0) op = 3'd7;
        else op = 3'($urandom_range(1, 6));
        send_cmd(op, 3'($urandom), rand_q(), rand_q(), rand_q(), rand_len(),
                 rand_len(), rand_len(), ($urandom_range(9) == 0) ? 16'd0 : rand_len());
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n) random_item();
        drain();
    endtask

    initial begin
        #20ms;
        $display("** multichannel_weight_envelope_unit: FAILED **");
        $finish;
    end

    initial begin
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        write_reg(REG_ACTIVE, 32'd8);
        write_reg(REG_TOP, 32'h0001_0000);
        write_reg(REG_BOTTOM, 32'h0000_0000);

        // directed: each mode, zero divisors, extremes
        send_cmd(OP_RAMP_F, 3'd0, 32'h0001_0000, 0, 0, 16'd4, 0, 0, 0);
        send_cmd(OP_RAMP_S, 3'd1, 32'hFFFE_0000, 32'h0000_8000, 0, 0, 0, 0, 0);
        send_cmd(OP_ACCEL, 3'd2, 32'h0004_0000, 32'h0000_1000, 32'h0000_2000, 0, 0, 0, 0);
        send_cmd(OP_BOUNCE, 3'd3, 0, 0, 0, 16'd8, 0, 0, 16'd3);
        send_cmd(OP_BEAT, 3'd4, 0, 0, 0, 16'd10, 16'd3, 16'd2, 16'd4);
        send_cmd(OP_BEAT, 3'd5, 0, 0, 0, 16'd6, 16'd0, 16'd1, 16'd0);
        send_cmd(OP_RAMP_F, 3'd6, 32'h7FFF_FFFF, 0, 0, 16'd0, 0, 0, 0);
        send_cmd(OP_RAMP_S, 3'd7, 32'h0000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
        repeat (4) tick();
        send_cmd(OP_RAMP_S, 3'd6, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_cmd(OP_ACCEL, 3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_cmd(OP_BOUNCE, 3'd0, 0, 0, 0, 16'hFFFF, 0, 0, 16'hFFFF);
        send_cmd(OP_BEAT, 3'd1, 0, 0, 0, 16'd2, 16'd2, 16'd3, 16'd2);
        send_cmd(3'd7, 3'd2, $urandom, $urandom, $urandom, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(OP_STOP, 3'd3, 0, 0, 0, 0, 0, 0, 0);
        repeat (5) tick();
        drain();

        random_phase(30, 0, 0);

        write_reg(REG_ACTIVE, 32'd1);
        write_reg(REG_TOP, 32'h7FFF_FFFF);
        write_reg(REG_BOTTOM, 32'h8000_0000);
        random_phase(20, 73, 0);

        write_reg(REG_ACTIVE, 32'd0);
        random_phase(5, 0, 0);

        write_reg(REG_ACTIVE, 32'hFFFF_FFFF);
        write_reg(REG_TOP, 32'h0002_0000);
        write_reg(REG_BOTTOM, 32'hFFFF_0000);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        repeat (12) random_item();
        random_phase(30, 0, 73);

        write_reg(REG_ACTIVE, 32'd5);
        write_reg(REG_TOP, 32'hFFFF_8000);
        write_reg(REG_BOTTOM, 32'h0003_0000);
        random_phase(20, 9, 9);

        write_reg(REG_ACTIVE, 32'd8);
        write_reg(REG_TOP, $urandom);
        write_reg(REG_BOTTOM, $urandom);
        random_phase(20, 0, 0);

        if (errors == 0) begin
            $display("** multichannel_weight_envelope_unit: PASSED **");
        end else begin
            $display("** multichannel_weight_envelope_unit: FAILED **");
        end
        $finish;
    end

endmodule
